/* hw/rtl/dslc_pkg.sv */
`default_nettype none
package dslc_pkg;

    localparam int HIDDEN_NEURONS_DEF = 32;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int WIDX_W   = 8;
    localparam int MEM_W    = 24;
    localparam int SCORE_W  = 32;
    localparam int CNT_W    = 19;
    localparam int WIN_W    = 11;
    localparam int LEAK_W   = 16;
    localparam int FTHR_W   = 23;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [15:0]       RST_DELTA_THR = 16'd256;
    localparam logic [15:0]       RST_LEAK      = 16'd58982;
    localparam logic [FTHR_W-1:0] RST_FIRE_THR  = 23'd4096;
    localparam logic [WIN_W-1:0]  RST_INTERVAL  = 11'd200;
    localparam logic [CNT_W-1:0]  RST_IDLE_CNT  = 19'd0;

    typedef enum logic [1:0] {
        REQ_SAMPLE,
        REQ_IN_WEIGHT,
        REQ_FAULT_WEIGHT,
        REQ_NORMAL_WEIGHT
    } t_req_type;

    typedef enum logic [2:0] {
        REG_DELTA_THR,
        REG_LEAK,
        REG_FIRE_THR,
        REG_INTERVAL,
        REG_IDLE_CNT
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [15:0]       delta_threshold;
        logic [LEAK_W-1:0] leak_factor;
        logic [FTHR_W-1:0] fire_threshold;
        logic [WIN_W-1:0]  decision_interval;
        logic [CNT_W-1:0]  idle_spike_count;
    } t_cfg;

    function automatic logic signed [SCORE_W-1:0] sat_add_score(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [WEIGHT_W-1:0] b
    );
        logic signed [SCORE_W:0] s;
        logic signed [SCORE_W-1:0] r;
        s = {a[SCORE_W-1], a} + (SCORE_W+1)'(b);
        if (s[SCORE_W] != s[SCORE_W-1]) begin
            r = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            r = s[SCORE_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/dslc_in_if.sv */
`default_nettype none
interface dslc_in_if;
    import dslc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic [WIDX_W-1:0]          weight_index;
    logic signed [WEIGHT_W-1:0] weight_value;

    modport source (
        output valid, req_type, sample, weight_index, weight_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, sample, weight_index, weight_value,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/dslc_out_if.sv */
`default_nettype none
interface dslc_out_if;
    import dslc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      status;
    logic                      idle_detected;
    logic [CNT_W-1:0]          spike_total;
    logic signed [SCORE_W-1:0] fault_score;
    logic signed [SCORE_W-1:0] normal_score;

    modport source (
        output valid, status, idle_detected, spike_total, fault_score, normal_score,
        input  ready
    );
    modport sink (
        input  valid, status, idle_detected, spike_total, fault_score, normal_score,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/delta_spike_lif_classifier_core.sv */
`default_nettype none
// A sample item occupies the block from the accepting cycle, through the neurons visited one per
// cycle through a single multiplier and the one read port of the membrane and weight memories,
// and a drain of the read and LIF registers, to a decision step. Weight writes are taken while
// idle, back to back. A decision result waits in an output register; if the previous result has
// not been taken when the next window closes, the block holds until it is. Membranes are cleared
// at reset and at each window end through per-neuron valid bits, so there is no clearing pass.
// Configuration is written through the APB port at byte address 4 * index.
module delta_spike_lif_classifier_core #(
    parameter int HIDDEN_NEURONS = dslc_pkg::HIDDEN_NEURONS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dslc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [dslc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [dslc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    dslc_in_if.sink                               i_req,
    dslc_out_if.source                            o_res
);
    import dslc_pkg::*;

    localparam int IDX_W = (HIDDEN_NEURONS > 1) ? $clog2(HIDDEN_NEURONS) : 1;

    t_cfg   w_cfg;
    t_state r_state;
    t_state n_state;

    logic signed [MEM_W-1:0]    r_mem_arr [HIDDEN_NEURONS];
    logic signed [WEIGHT_W-1:0] r_iw_arr  [HIDDEN_NEURONS];
    logic signed [WEIGHT_W-1:0] r_fw_arr  [HIDDEN_NEURONS];
    logic signed [WEIGHT_W-1:0] r_nw_arr  [HIDDEN_NEURONS];
    logic [HIDDEN_NEURONS-1:0]  r_mvld;

    logic [IDX_W-1:0]           r_idx;
    logic                       r_rd_vld;
    logic [IDX_W-1:0]           r_rd_idx;
    logic signed [MEM_W-1:0]    r_m_rd;
    logic                       r_mv_rd;
    logic signed [WEIGHT_W-1:0] r_iw_rd;
    logic signed [WEIGHT_W-1:0] r_fw_rd;
    logic signed [WEIGHT_W-1:0] r_nw_rd;
    logic signed [WEIGHT_W-1:0] r_fw_d;
    logic signed [WEIGHT_W-1:0] r_nw_d;

    logic                       r_spike;
    logic                       r_prev_vld;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [WIN_W-1:0]           r_win;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [SCORE_W-1:0]  r_facc;
    logic signed [SCORE_W-1:0]  r_nacc;

    logic                       r_out_vld;
    logic                       r_out_status;
    logic                       r_out_idle;
    logic [CNT_W-1:0]           r_out_cnt;
    logic signed [SCORE_W-1:0]  r_out_fs;
    logic signed [SCORE_W-1:0]  r_out_ns;

    logic                       w_accept;
    logic                       w_is_sample;
    logic                       w_wr_ok;
    logic [IDX_W-1:0]           w_widx;
    logic signed [SAMPLE_W:0]   w_diff;
    logic [SAMPLE_W:0]          w_abs;
    logic                       w_issue;
    logic                       w_last;
    logic                       w_decide;
    logic                       w_load;
    logic [WIN_W-1:0]           w_win_inc;
    logic                       w_close;
    logic                       w_idle;
    logic                       w_out_take;

    logic                       w_lif_vld;
    logic [IDX_W-1:0]           w_lif_idx;
    logic signed [MEM_W-1:0]    w_lif_mem;
    logic                       w_lif_fire;

    dslc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dslc_lif_unit #(
        .HIDDEN_NEURONS (HIDDEN_NEURONS)
    ) u_lif (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_rd_vld),
        .i_idx      (r_rd_idx),
        .i_mem      (r_mv_rd ? r_m_rd : '0),
        .i_weight   (r_iw_rd),
        .i_spike    (r_spike),
        .i_leak     (w_cfg.leak_factor),
        .i_fire_thr (w_cfg.fire_threshold),
        .o_vld      (w_lif_vld),
        .o_idx      (w_lif_idx),
        .o_mem      (w_lif_mem),
        .o_fire     (w_lif_fire)
    );

    assign w_accept    = i_req.valid & i_req.ready;
    assign w_is_sample = (i_req.req_type == REQ_SAMPLE);
    assign w_wr_ok     = ({1'b0, i_req.weight_index} < (WIDX_W+1)'(HIDDEN_NEURONS));
    assign w_widx      = IDX_W'(i_req.weight_index);
    assign w_diff      = {i_req.sample[SAMPLE_W-1], i_req.sample} - {r_prev[SAMPLE_W-1], r_prev};
    assign w_abs       = w_diff[SAMPLE_W] ? (SAMPLE_W+1)'(-w_diff) : (SAMPLE_W+1)'(w_diff);
    assign w_last      = (r_idx == IDX_W'(HIDDEN_NEURONS - 1));
    assign w_win_inc   = r_win + WIN_W'(1);
    assign w_close     = (w_win_inc >= w_cfg.decision_interval);
    assign w_idle      = (r_cnt < w_cfg.idle_spike_count);
    assign w_out_take  = o_res.valid & o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        w_issue     = 1'b0;
        w_decide    = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid && w_is_sample) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                w_issue = 1'b1;
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !w_lif_vld) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!w_close) begin
                    w_decide = 1'b1;
                    n_state  = ST_IDLE;
                end else if (!r_out_vld || o_res.ready) begin
                    w_decide = 1'b1;
                    w_load   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_sample && w_wr_ok) begin
            unique case (i_req.req_type)
                REQ_IN_WEIGHT:     r_iw_arr[w_widx] <= i_req.weight_value;
                REQ_FAULT_WEIGHT:  r_fw_arr[w_widx] <= i_req.weight_value;
                REQ_NORMAL_WEIGHT: r_nw_arr[w_widx] <= i_req.weight_value;
                default: begin
                end
            endcase
        end
        if (w_lif_vld) begin
            r_mem_arr[w_lif_idx] <= w_lif_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_idx <= r_idx;
            r_m_rd   <= r_mem_arr[r_idx];
            r_mv_rd  <= r_mvld[r_idx];
            r_iw_rd  <= r_iw_arr[r_idx];
            r_fw_rd  <= r_fw_arr[r_idx];
            r_nw_rd  <= r_nw_arr[r_idx];
        end
        if (r_rd_vld) begin
            r_fw_d <= r_fw_rd;
            r_nw_d <= r_nw_rd;
        end
        if (w_accept && w_is_sample) begin
            r_prev <= i_req.sample;
        end
        if (w_load) begin
            r_out_status <= w_idle || (r_nacc <= r_facc);
            r_out_idle   <= w_idle;
            r_out_cnt    <= r_cnt;
            r_out_fs     <= r_facc;
            r_out_ns     <= r_nacc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_spike    <= 1'b0;
            r_prev_vld <= 1'b0;
            r_mvld     <= '0;
            r_win      <= '0;
            r_cnt      <= '0;
            r_facc     <= '0;
            r_nacc     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_accept && w_is_sample) begin
                r_spike    <= r_prev_vld && (w_abs > {1'b0, w_cfg.delta_threshold});
                r_prev_vld <= 1'b1;
                r_idx      <= '0;
            end else if (w_issue) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (w_lif_vld) begin
                r_mvld[w_lif_idx] <= 1'b1;
                if (w_lif_fire) begin
                    r_facc <= sat_add_score(r_facc, r_fw_d);
                    r_nacc <= sat_add_score(r_nacc, r_nw_d);
                    if (r_cnt != '1) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
            end
            if (w_decide) begin
                r_win <= w_close ? '0 : w_win_inc;
            end
            if (w_load) begin
                r_mvld <= '0;
                r_cnt  <= '0;
                r_facc <= '0;
                r_nacc <= '0;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (w_out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.status        = r_out_status;
    assign o_res.idle_detected = r_out_idle;
    assign o_res.spike_total   = r_out_cnt;
    assign o_res.fault_score   = r_out_fs;
    assign o_res.normal_score  = r_out_ns;
endmodule
`default_nettype wire

/* hw/rtl/dslc_apb_regs.sv */
`default_nettype none
module dslc_apb_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dslc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [dslc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [dslc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output dslc_pkg::t_cfg                        o_cfg
);
    import dslc_pkg::*;

    t_cfg r_cfg;
    logic w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delta_threshold   <= RST_DELTA_THR;
            r_cfg.leak_factor       <= RST_LEAK;
            r_cfg.fire_threshold    <= RST_FIRE_THR;
            r_cfg.decision_interval <= RST_INTERVAL;
            r_cfg.idle_spike_count  <= RST_IDLE_CNT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DELTA_THR: r_cfg.delta_threshold   <= pwdata[15:0];
                REG_LEAK:      r_cfg.leak_factor       <= pwdata[LEAK_W-1:0];
                REG_FIRE_THR:  r_cfg.fire_threshold    <= pwdata[FTHR_W-1:0];
                REG_INTERVAL:  r_cfg.decision_interval <= pwdata[WIN_W-1:0];
                REG_IDLE_CNT:  r_cfg.idle_spike_count  <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DELTA_THR: prdata = APB_DATA_W'(r_cfg.delta_threshold);
            REG_LEAK:      prdata = APB_DATA_W'(r_cfg.leak_factor);
            REG_FIRE_THR:  prdata = APB_DATA_W'(r_cfg.fire_threshold);
            REG_INTERVAL:  prdata = APB_DATA_W'(r_cfg.decision_interval);
            REG_IDLE_CNT:  prdata = APB_DATA_W'(r_cfg.idle_spike_count);
            default:       prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/dslc_lif_unit.sv */
`default_nettype none
module dslc_lif_unit #(
    parameter int HIDDEN_NEURONS = dslc_pkg::HIDDEN_NEURONS_DEF,
    localparam int IDX_W = (HIDDEN_NEURONS > 1) ? $clog2(HIDDEN_NEURONS) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_vld,
    input  wire logic [IDX_W-1:0]                    i_idx,
    input  wire logic signed [dslc_pkg::MEM_W-1:0]   i_mem,
    input  wire logic signed [dslc_pkg::WEIGHT_W-1:0] i_weight,
    input  wire logic                                i_spike,
    input  wire logic [dslc_pkg::LEAK_W-1:0]         i_leak,
    input  wire logic [dslc_pkg::FTHR_W-1:0]         i_fire_thr,
    output logic                                     o_vld,
    output logic [IDX_W-1:0]                         o_idx,
    output logic signed [dslc_pkg::MEM_W-1:0]        o_mem,
    output logic                                     o_fire
);
    import dslc_pkg::*;

    localparam int PROD_W = MEM_W + LEAK_W + 1;

    logic                       r_vld;
    logic [IDX_W-1:0]           r_idx;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [WEIGHT_W-1:0] r_w;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [MEM_W:0]      w_sum;
    logic signed [MEM_W-1:0]    w_sat;
    logic signed [MEM_W-1:0]    w_thr;

    assign w_prod = i_mem * $signed({1'b0, i_leak});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_idx  <= i_idx;
            r_prod <= w_prod;
            r_w    <= i_spike ? i_weight : '0;
        end
    end

    // The arithmetic shift of the product floors toward minus infinity.
    always_comb begin
        w_sum = $signed({r_prod[PROD_W-2], r_prod[PROD_W-2:LEAK_W]}) + (MEM_W+1)'(r_w);
        if (w_sum[MEM_W] != w_sum[MEM_W-1]) begin
            w_sat = w_sum[MEM_W] ? {1'b1, {(MEM_W-1){1'b0}}} : {1'b0, {(MEM_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[MEM_W-1:0];
        end
        w_thr  = $signed({1'b0, i_fire_thr});
        o_fire = (w_sat >= w_thr);
        o_mem  = o_fire ? (w_sat - w_thr) : w_sat;
    end

    assign o_vld = r_vld;
    assign o_idx = r_idx;
endmodule
`default_nettype wire
